FILE: sv/stmpg_pkg.sv
// shared constants, table types and table builders for the stereo pan/gain mixer
`default_nettype none

package stmpg_pkg;

	localparam int TRACKS_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int TRACK_COUNT_RST = 8;

	localparam int ACC_W    = 40;
	localparam int GAIN_W   = 11;
	localparam int PAN_W    = 8;
	localparam int COEF_W   = 17;
	localparam int FAC_W    = 18;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int GAIN_ENTRIES = 661;
	localparam int GAIN_IDX_W   = $clog2(GAIN_ENTRIES);
	localparam int GAIN_UNITY   = 600;
	localparam int PAN_ENTRIES  = 201;
	localparam int PAN_IDX_W    = $clog2(PAN_ENTRIES);
	localparam int PAN_LIM      = 100;

	localparam logic signed [GAIN_W-1:0] GAIN_LO = -11'sd600;
	localparam logic signed [GAIN_W-1:0] GAIN_HI = 11'sd60;
	localparam logic signed [PAN_W-1:0]  PAN_LO  = -8'sd100;
	localparam logic signed [PAN_W-1:0]  PAN_HI  = 8'sd100;

	// register indexes
	localparam logic REG_TRACK_COUNT = 1'b0;

	localparam logic [63:0] UP_STEP   = 64'd49733377;
	localparam logic [63:0] DOWN_STEP = 64'd49164084;
	localparam logic signed [63:0] ROT_COS = 64'sd1073708707;
	localparam logic signed [63:0] ROT_SIN = 64'sd8433062;

	typedef logic [GAIN_ENTRIES-1:0][COEF_W-1:0] gain_tab_t;
	typedef logic [PAN_ENTRIES-1:0][COEF_W-1:0]  pan_tab_t;

	// 10^(g/200) in q1.16, built by repeated 0.1 db steps in q32
	function automatic gain_tab_t build_gain_tab();
		gain_tab_t   tab;
		logic [63:0] v;
		logic [63:0] t;
		int          i;
		tab = '0;
		v = 64'd1 << 32;
		t = v + (64'd1 << 15);
		tab[GAIN_UNITY] = t[32:16];
		for (i = GAIN_UNITY + 1; i < GAIN_ENTRIES; i++) begin
			v = v + ((v * UP_STEP + (64'd1 << 31)) >> 32);
			t = v + (64'd1 << 15);
			tab[i] = t[32:16];
		end
		v = 64'd1 << 32;
		for (i = GAIN_UNITY - 1; i >= 0; i--) begin
			v = v - ((v * DOWN_STEP + (64'd1 << 31)) >> 32);
			t = v + (64'd1 << 15);
			tab[i] = t[32:16];
		end
		return tab;
	endfunction

	// quarter sine in q1.16 from a q30 rotation, upper half by symmetry
	function automatic pan_tab_t build_pan_tab();
		pan_tab_t           tab;
		logic signed [63:0] c;
		logic signed [63:0] s;
		logic signed [63:0] nc;
		logic signed [63:0] ns;
		logic [63:0]        t;
		int                 i;
		tab = '0;
		c = 64'sd1 << 30;
		s = 64'sd0;
		for (i = 0; i <= PAN_LIM; i++) begin
			t = s + (64'sd1 << 13);
			tab[i] = t[30:14];
			t = c + (64'sd1 << 13);
			tab[2 * PAN_LIM - i] = t[30:14];
			nc = c * ROT_COS - s * ROT_SIN + (64'sd1 << 29);
			ns = s * ROT_COS + c * ROT_SIN + (64'sd1 << 29);
			if (nc < 0) begin
				nc = 64'sd0;
			end
			c = nc >>> 30;
			s = ns >>> 30;
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

FILE: sv/stereo_track_mixer_pan_gain.sv
// stereo track mixer: per-track db gain and constant-power pan into two accumulators
// sequence: an active track is fetched, then makes four passes through the single shared multiplier
//   and adds into the left and then the right sum; an ignored track skips the multiplier; a last
//   mark then emits the pair once the output register is free; a new track is taken only in idle
// reset: asynchronous, active low; sums cleared, track_count back to 8, output empty
`default_nettype none

module stereo_track_mixer_pan_gain #(
	parameter int TRACKS_MAX  = stmpg_pkg::TRACKS_MAX_DEF,
	parameter int SAMPLE_BITS = stmpg_pkg::SAMPLE_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// track transfer in
	input  wire                               item_valid,
	output logic                              item_ready,
	input  wire  [$clog2(TRACKS_MAX)-1:0]     track,
	input  wire  signed [SAMPLE_BITS-1:0]     sample,
	input  wire  signed [stmpg_pkg::GAIN_W-1:0] gain_tenth_db,
	input  wire  signed [stmpg_pkg::PAN_W-1:0]  pan_hundredths,
	input  wire                               last_track,
	// mix transfer out
	output logic                              mix_valid,
	input  wire                               mix_ready,
	output logic signed [SAMPLE_BITS-1:0]     mix_left,
	output logic signed [SAMPLE_BITS-1:0]     mix_right,
	output logic                              clipped,
	// configuration port
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [stmpg_pkg::APB_AW-1:0]      paddr,
	input  wire  [stmpg_pkg::APB_DW-1:0]      pwdata,
	output logic [stmpg_pkg::APB_DW-1:0]      prdata,
	output logic                              pready
);

	localparam int TCNT_W  = $clog2(TRACKS_MAX + 1);
	localparam int ACC_W   = stmpg_pkg::ACC_W;
	localparam int FAC_W   = stmpg_pkg::FAC_W;
	localparam int COEF_W  = stmpg_pkg::COEF_W;
	localparam int MUL_A_W = (SAMPLE_BITS > FAC_W) ? SAMPLE_BITS : FAC_W;
	localparam int PROD_W  = MUL_A_W + FAC_W;
	localparam int HI_W    = PROD_W - 16;

	localparam stmpg_pkg::gain_tab_t GainTab = stmpg_pkg::build_gain_tab();
	localparam stmpg_pkg::pan_tab_t  PanTab  = stmpg_pkg::build_pan_tab();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL_GL,
		ST_MUL_GR,
		ST_MUL_SL,
		ST_MUL_SR,
		ST_ACC_R,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [TCNT_W-1:0] track_count_q;
	logic              cfg_wr;

	// captured transfer
	logic signed [SAMPLE_BITS-1:0]          smp_q;
	logic [stmpg_pkg::GAIN_IDX_W-1:0]       gidx_q;
	logic [stmpg_pkg::PAN_IDX_W-1:0]        pidx_q;
	logic                                   active_q;
	logic                                   last_q;

	// table reads and shared multiplier
	logic [COEF_W-1:0]        gain_q;
	logic [COEF_W-1:0]        pan_l_q;
	logic [COEF_W-1:0]        pan_r_q;
	logic signed [FAC_W-1:0]  fac_l_q;
	logic signed [FAC_W-1:0]  fac_r_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [ACC_W-1:0] sum_l_q;
	logic signed [ACC_W-1:0] sum_r_q;

	logic item_xfer;
	logic emit_go;

	logic signed [stmpg_pkg::GAIN_W-1:0] gain_cl;
	logic signed [stmpg_pkg::PAN_W-1:0]  pan_cl;
	logic signed [stmpg_pkg::GAIN_W-1:0] gidx_full;
	logic signed [stmpg_pkg::PAN_W:0]    pidx_full;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [FAC_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [HI_W-1:0]    prod_hi;
	logic signed [ACC_W-1:0]   contrib;

	logic [stmpg_pkg::PAN_IDX_W-1:0] pidx_l;

	logic                         clip_l;
	logic                         clip_r;
	logic signed [SAMPLE_BITS-1:0] sat_l;
	logic signed [SAMPLE_BITS-1:0] sat_r;
	logic signed [SAMPLE_BITS-1:0] smax;
	logic signed [SAMPLE_BITS-1:0] smin;

	// ---------------------------------------------------------------- apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == stmpg_pkg::REG_TRACK_COUNT);

	always_comb begin
		prdata = '0;
		if (paddr[2] == stmpg_pkg::REG_TRACK_COUNT) begin
			prdata = stmpg_pkg::APB_DW'(track_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= TCNT_W'(stmpg_pkg::TRACK_COUNT_RST);
		end else if (cfg_wr) begin
			track_count_q <= pwdata[TCNT_W-1:0];
		end
	end

	// ---------------------------------------------------------------- input side
	assign item_ready = (state_q == ST_IDLE);
	assign item_xfer  = item_valid && item_ready;

	// clamp gain and pan into the table ranges
	always_comb begin
		gain_cl = gain_tenth_db;
		if (gain_tenth_db < stmpg_pkg::GAIN_LO) begin
			gain_cl = stmpg_pkg::GAIN_LO;
		end else if (gain_tenth_db > stmpg_pkg::GAIN_HI) begin
			gain_cl = stmpg_pkg::GAIN_HI;
		end
		pan_cl = pan_hundredths;
		if (pan_hundredths < stmpg_pkg::PAN_LO) begin
			pan_cl = stmpg_pkg::PAN_LO;
		end else if (pan_hundredths > stmpg_pkg::PAN_HI) begin
			pan_cl = stmpg_pkg::PAN_HI;
		end
		gidx_full = gain_cl - stmpg_pkg::GAIN_LO;
		pidx_full = (stmpg_pkg::PAN_W + 1)'(pan_cl) + (stmpg_pkg::PAN_W + 1)'(stmpg_pkg::PAN_LIM);
	end

	// left factor reads the mirrored entry
	assign pidx_l = stmpg_pkg::PAN_IDX_W'(2 * stmpg_pkg::PAN_LIM) - pidx_q;

	// ---------------------------------------------------------------- shared multiplier
	// gain x pan for the two channel factors, then sample x factor for the two sums
	always_comb begin
		unique case (state_q)
			ST_MUL_GL: begin
				mul_a = MUL_A_W'($signed({1'b0, gain_q}));
				mul_b = FAC_W'($signed({1'b0, pan_l_q}));
			end
			ST_MUL_GR: begin
				mul_a = MUL_A_W'($signed({1'b0, gain_q}));
				mul_b = FAC_W'($signed({1'b0, pan_r_q}));
			end
			ST_MUL_SL: begin
				mul_a = MUL_A_W'(smp_q);
				mul_b = fac_l_q;
			end
			default: begin
				mul_a = MUL_A_W'(smp_q);
				mul_b = fac_r_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// round half up: add half an lsb, then floor shift by 16
	assign prod_rnd = prod_q + PROD_W'(32768);
	assign prod_hi  = prod_rnd[PROD_W-1:16];
	assign contrib  = ACC_W'(prod_hi);

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			smp_q    <= sample;
			gidx_q   <= gidx_full[stmpg_pkg::GAIN_IDX_W-1:0];
			pidx_q   <= pidx_full[stmpg_pkg::PAN_IDX_W-1:0];
			active_q <= (TCNT_W'(track) < track_count_q);
			last_q   <= last_track;
		end
		if (state_q == ST_FETCH) begin
			gain_q  <= GainTab[gidx_q];
			pan_r_q <= PanTab[pidx_q];
			pan_l_q <= PanTab[pidx_l];
		end
		if (state_q == ST_MUL_GL || state_q == ST_MUL_GR
				|| state_q == ST_MUL_SL || state_q == ST_MUL_SR) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_MUL_GR) begin
			fac_l_q <= prod_hi[FAC_W-1:0];
		end
		if (state_q == ST_MUL_SL) begin
			fac_r_q <= prod_hi[FAC_W-1:0];
		end
	end

	// ---------------------------------------------------------------- saturation
	assign smax = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	assign smin = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	always_comb begin
		clip_l = (sum_l_q[ACC_W-1:SAMPLE_BITS-1] != {(ACC_W - SAMPLE_BITS + 1){sum_l_q[ACC_W-1]}});
		clip_r = (sum_r_q[ACC_W-1:SAMPLE_BITS-1] != {(ACC_W - SAMPLE_BITS + 1){sum_r_q[ACC_W-1]}});
		sat_l  = clip_l ? (sum_l_q[ACC_W-1] ? smin : smax) : sum_l_q[SAMPLE_BITS-1:0];
		sat_r  = clip_r ? (sum_r_q[ACC_W-1] ? smin : smax) : sum_r_q[SAMPLE_BITS-1:0];
	end

	// the output register may still hold an earlier pair; emit waits for it to drain
	assign emit_go = (state_q == ST_EMIT) && (!mix_valid || mix_ready);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_l_q   <= '0;
			sum_r_q   <= '0;
			mix_valid <= 1'b0;
			mix_left  <= '0;
			mix_right <= '0;
			clipped   <= 1'b0;
		end else begin
			if (emit_go) begin
				mix_valid <= 1'b1;
				mix_left  <= sat_l;
				mix_right <= sat_r;
				clipped   <= clip_l || clip_r;
			end else if (mix_ready) begin
				mix_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					// an ignored track skips the multiplier
					if (active_q) begin
						state_q <= ST_MUL_GL;
					end else if (last_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL_GL: state_q <= ST_MUL_GR;
				ST_MUL_GR: state_q <= ST_MUL_SL;
				ST_MUL_SL: state_q <= ST_MUL_SR;
				ST_MUL_SR: begin
					sum_l_q <= sum_l_q + contrib;
					state_q <= ST_ACC_R;
				end
				ST_ACC_R: begin
					sum_r_q <= sum_r_q + contrib;
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_go) begin
						sum_l_q <= '0;
						sum_r_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/stmpg_checker.sv
// port-level checks for the stereo pan/gain mixer, bound to the top level
`default_nettype none

module stmpg_checker #(
	parameter int SAMPLE_BITS = stmpg_pkg::SAMPLE_BITS_DEF
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          item_valid,
	input wire                          item_ready,
	input wire                          mix_valid,
	input wire                          mix_ready,
	input wire signed [SAMPLE_BITS-1:0] mix_left,
	input wire signed [SAMPLE_BITS-1:0] mix_right,
	input wire                          clipped
);

	localparam logic signed [SAMPLE_BITS-1:0] SMax = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMin = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	// one track at a time: in the cycle after a transfer the unit is not ready
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("item accepted while the shared unit is busy");

	// a clip flag needs at least one channel pinned at a rail
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_valid && clipped) |-> (mix_left == SMax || mix_left == SMin
			|| mix_right == SMax || mix_right == SMin))
		else $error("clipped set with neither channel saturated");

	// a waiting mix pair is neither dropped nor changed
	a_mix_held: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_valid && !mix_ready) |=> mix_valid && $stable(mix_left)
			&& $stable(mix_right) && $stable(clipped))
		else $error("mix transfer changed while stalled");

	// mix_valid never rises directly after an accepted track transfer
	a_no_spurious_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mix_valid) |-> !$past(item_valid && item_ready))
		else $error("mix pair appeared the cycle after a transfer");

endmodule

bind stereo_track_mixer_pan_gain stmpg_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_stmpg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.mix_valid  (mix_valid),
	.mix_ready  (mix_ready),
	.mix_left   (mix_left),
	.mix_right  (mix_right),
	.clipped    (clipped)
);

`default_nettype wire

FILE: tb/sv/stereo_track_mixer_pan_gain_tb.sv
// testbench for the stereo pan/gain track mixer: directed table, full-scale run, random frames
`default_nettype none

module stereo_track_mixer_pan_gain_tb;

	localparam int TRK_W  = $clog2(stmpg_pkg::TRACKS_MAX_DEF);
	localparam int SMP_W  = stmpg_pkg::SAMPLE_BITS_DEF;
	localparam int GDB_W  = stmpg_pkg::GAIN_W;
	localparam int PAN_W  = stmpg_pkg::PAN_W;
	localparam int ACC_W  = stmpg_pkg::ACC_W;
	localparam int APB_AW = stmpg_pkg::APB_AW;
	localparam int APB_DW = stmpg_pkg::APB_DW;

	localparam longint SMP_HI = (64'sd1 <<< (SMP_W - 1)) - 64'sd1;
	localparam longint SMP_LO = -SMP_HI - 64'sd1;

	// gain law: 0.1 db steps up and down from unity in q32
	localparam longint unsigned DB_STEP_UP   = 64'd49733377;
	localparam longint unsigned DB_STEP_DOWN = 64'd49164084;
	// pan law: rotation by pi/400 in q30
	localparam longint ROT_C = 64'sd1073708707;
	localparam longint ROT_S = 64'sd8433062;

	localparam int GAIN_MIN = -600;
	localparam int GAIN_MAX = 60;
	localparam int PAN_MAX  = 100;

	localparam int STALL_LIMIT      = 4000;
	localparam int RX_HOLD_CYCLES   = 400;
	localparam int HOLD_ITEMS       = 40;
	localparam int DRAIN_PAUSE      = 16;
	localparam int PHASE_ITEMS      = 155;
	localparam int N_PHASES         = 8;
	localparam int FULL_SCALE_ITEMS = 100;

	typedef struct packed {
		logic [TRK_W-1:0]        trk;
		logic signed [SMP_W-1:0] smp;
		logic signed [GDB_W-1:0] gdb;
		logic signed [PAN_W-1:0] pan;
		logic                    last;
	} track_item_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] mix_l;
		logic signed [SMP_W-1:0] mix_r;
		logic                    clip;
	} mix_t;

	typedef struct packed {
		track_item_t it;
		logic        typed;
		mix_t        want;
	} dir_row_t;

	// block ports
	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    item_valid     = 1'b0;
	logic                    item_ready;
	logic [TRK_W-1:0]        track          = '0;
	logic signed [SMP_W-1:0] sample         = '0;
	logic signed [GDB_W-1:0] gain_tenth_db  = '0;
	logic signed [PAN_W-1:0] pan_hundredths = '0;
	logic                    last_track     = 1'b0;
	logic                    mix_valid;
	logic                    mix_ready      = 1'b0;
	logic signed [SMP_W-1:0] mix_left;
	logic signed [SMP_W-1:0] mix_right;
	logic                    clipped;
	logic                    psel           = 1'b0;
	logic                    penable        = 1'b0;
	logic                    pwrite         = 1'b0;
	logic [APB_AW-1:0]       paddr          = '0;
	logic [APB_DW-1:0]       pwdata         = '0;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;

	// predictor state: factor tables, track limit and the two running sums
	longint                  gain_q16 [0:GAIN_MAX-GAIN_MIN];
	longint                  sine_q16 [0:2*PAN_MAX];
	logic [6:0]              trk_limit;
	logic signed [ACC_W-1:0] acc_left;
	logic signed [ACC_W-1:0] acc_right;

	mix_t     mix_expected [$];
	dir_row_t directed_rows [$];
	mix_t     mon_want;

	int n_errors     = 0;
	int n_counted    = 0;
	int stall_cycles = 0;
	bit quiet        = 1'b0;
	bit rx_hold      = 1'b0;

	stereo_track_mixer_pan_gain i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.track          (track),
		.sample         (sample),
		.gain_tenth_db  (gain_tenth_db),
		.pan_hundredths (pan_hundredths),
		.last_track     (last_track),
		.mix_valid      (mix_valid),
		.mix_ready      (mix_ready),
		.mix_left       (mix_left),
		.mix_right      (mix_right),
		.clipped        (clipped),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		n_errors++;
	endtask

	// linear gain in q1.16 and quarter sine in q1.16, same rounding as the hardware tables
	function automatic void build_factor_tables();
		longint unsigned v;
		longint          c;
		longint          s;
		longint          nc;
		longint          ns;
		int              i;
		v = 64'd1 << 32;
		gain_q16[-GAIN_MIN] = longint'((v + 64'd32768) >> 16);
		for (i = -GAIN_MIN + 1; i <= GAIN_MAX - GAIN_MIN; i++) begin
			v = v + ((v * DB_STEP_UP + 64'h8000_0000) >> 32);
			gain_q16[i] = longint'((v + 64'd32768) >> 16);
		end
		v = 64'd1 << 32;
		for (i = -GAIN_MIN - 1; i >= 0; i--) begin
			v = v - ((v * DB_STEP_DOWN + 64'h8000_0000) >> 32);
			gain_q16[i] = longint'((v + 64'd32768) >> 16);
		end
		c = 64'sd1 <<< 30;
		s = 64'sd0;
		for (i = 0; i <= PAN_MAX; i++) begin
			sine_q16[i] = (s + 64'sd8192) >>> 14;
			sine_q16[2 * PAN_MAX - i] = (c + 64'sd8192) >>> 14;
			nc = c * ROT_C - s * ROT_S + (64'sd1 <<< 29);
			ns = s * ROT_C + c * ROT_S + (64'sd1 <<< 29);
			if (nc < 0) begin
				nc = 64'sd0;
			end
			c = nc >>> 30;
			s = ns >>> 30;
		end
	endfunction

	// one track item into the sums; returns 1 with the stereo pair when the frame closes
	function automatic bit mix_predict(input track_item_t it, output mix_t r);
		int     g;
		int     p;
		longint lin;
		longint ml;
		longint mr;
		longint sx;
		longint dl;
		longint dr;
		longint tl;
		longint tr;
		logic   clip;
		r = '0;
		mix_predict = 1'b0;
		if ({1'b0, it.trk} < trk_limit) begin
			g = $signed(it.gdb);
			p = $signed(it.pan);
			if (g < GAIN_MIN) g = GAIN_MIN;
			if (g > GAIN_MAX) g = GAIN_MAX;
			if (p < -PAN_MAX) p = -PAN_MAX;
			if (p > PAN_MAX) p = PAN_MAX;
			lin = gain_q16[g - GAIN_MIN];
			ml = (lin * sine_q16[PAN_MAX - p] + 64'sd32768) >>> 16;
			mr = (lin * sine_q16[PAN_MAX + p] + 64'sd32768) >>> 16;
			sx = $signed(it.smp);
			// round half up, i.e. floor after adding one half
			dl = (sx * ml + 64'sd32768) >>> 16;
			dr = (sx * mr + 64'sd32768) >>> 16;
			acc_left  = acc_left + dl[ACC_W-1:0];
			acc_right = acc_right + dr[ACC_W-1:0];
		end
		if (it.last) begin
			tl = acc_left;
			tr = acc_right;
			clip = 1'b0;
			if (tl > SMP_HI) begin
				tl = SMP_HI;
				clip = 1'b1;
			end else if (tl < SMP_LO) begin
				tl = SMP_LO;
				clip = 1'b1;
			end
			if (tr > SMP_HI) begin
				tr = SMP_HI;
				clip = 1'b1;
			end else if (tr < SMP_LO) begin
				tr = SMP_LO;
				clip = 1'b1;
			end
			r.mix_l = tl[SMP_W-1:0];
			r.mix_r = tr[SMP_W-1:0];
			r.clip  = clip;
			acc_left  = '0;
			acc_right = '0;
			mix_predict = 1'b1;
		end
	endfunction

	function automatic dir_row_t dir_row(input int trk, input int smp, input int gdb, input int pan,
			input bit last, input bit typed, input int wl, input int wr, input bit wc);
		dir_row_t r;
		r.it.trk   = trk[TRK_W-1:0];
		r.it.smp   = smp[SMP_W-1:0];
		r.it.gdb   = gdb[GDB_W-1:0];
		r.it.pan   = pan[PAN_W-1:0];
		r.it.last  = last;
		r.typed    = typed;
		r.want.mix_l = wl[SMP_W-1:0];
		r.want.mix_r = wr[SMP_W-1:0];
		r.want.clip  = wc;
		return r;
	endfunction

	// append one row to the directed table
	function automatic void add_row(input dir_row_t r);
		directed_rows = {directed_rows, r};
	endfunction

	// random content: samples biased to extremes and small values, gain and pan mostly in range
	function automatic track_item_t random_track(input int trk, input bit last);
		track_item_t it;
		int          sel;
		it.trk  = trk[TRK_W-1:0];
		it.last = last;
		it.smp  = SMP_W'($urandom);
		sel = $urandom_range(9);
		if (sel == 0) begin
			it.smp = {1'b0, {(SMP_W-1){1'b1}}};
		end else if (sel == 1) begin
			it.smp = {1'b1, {(SMP_W-1){1'b0}}};
		end else if (sel <= 3) begin
			it.smp = $signed(it.smp) >>> $urandom_range(SMP_W - 1, 8);
		end
		if ($urandom_range(99) < 85) begin
			it.gdb = GDB_W'($urandom_range(GAIN_MAX - GAIN_MIN) + GAIN_MIN);
		end else begin
			it.gdb = GDB_W'($urandom);
		end
		if ($urandom_range(99) < 85) begin
			it.pan = PAN_W'($urandom_range(2 * PAN_MAX) - PAN_MAX);
		end else begin
			it.pan = PAN_W'($urandom);
		end
		return it;
	endfunction

	// one track transfer, with an optional random gap before it; the sum update and any
	// expected pair are taken at the edge that accepts the transfer
	task automatic send_track(input track_item_t it, input bit typed, input mix_t want);
		mix_t r;
		if (!quiet && $urandom_range(99) < 26) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 26);
		end
		item_valid     <= 1'b1;
		track          <= it.trk;
		sample         <= it.smp;
		gain_tenth_db  <= it.gdb;
		pan_hundredths <= it.pan;
		last_track     <= it.last;
		do @(posedge clk); while (!item_ready);
		if ({1'b0, it.trk} < trk_limit || it.last) begin
			n_counted++;
		end
		if (mix_predict(it, r)) begin
			mix_expected = {mix_expected, (typed ? want : r)};
		end
	endtask

	// drop valid, wait for every pending pair, then let the last tracks drain out
	task automatic wait_mix_drained();
		item_valid <= 1'b0;
		while (mix_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// write track_count then read it back in a back-to-back transfer; upper data bits are noise
	task automatic set_track_count(input int lim);
		logic [APB_DW-1:0] wdata;
		wdata = ($urandom & ~32'h7f) | (lim & 32'h7f);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * stmpg_pkg::REG_TRACK_COUNT);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		trk_limit = wdata[6:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[6:0] !== trk_limit) begin
			report_mismatch($sformatf("track_count read back %0d, written %0d", prdata[6:0],
				trk_limit));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// receiver: random back-pressure, none in quiet stretches, one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				mix_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else if (quiet) begin
				mix_ready <= 1'b1;
			end else begin
				mix_ready <= ($urandom_range(99) >= 26);
			end
		end
	end

	// every mix transfer against the oldest pending pair
	always @(posedge clk) begin
		if (arst_n && mix_valid && mix_ready) begin
			if (mix_expected.size() == 0) begin
				report_mismatch($sformatf("mix transfer with nothing pending: left %0d right %0d",
					mix_left, mix_right));
			end else begin
				mon_want = mix_expected.pop_front();
				if (mix_left !== mon_want.mix_l) begin
					report_mismatch($sformatf("mix_left %0d, expected %0d", mix_left,
						mon_want.mix_l));
				end
				if (mix_right !== mon_want.mix_r) begin
					report_mismatch($sformatf("mix_right %0d, expected %0d", mix_right,
						mon_want.mix_r));
				end
				if (clipped !== mon_want.clip) begin
					report_mismatch($sformatf("clipped %0b, expected %0b", clipped,
						mon_want.clip));
				end
			end
		end
	end

	// watchdog: too long without any transfer on any port ends the run
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (mix_valid && mix_ready) || (psel && penable && pready))
		begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int       ph;
		int       k;
		int       n;
		int       span;
		int       lim;
		int       start;
		dir_row_t row;
		int       phase_limit [0:6];

		phase_limit = '{2, 64, 0, 127, 1, 63, 8};
		build_factor_tables();
		trk_limit = 7'd8;
		acc_left  = '0;
		acc_right = '0;

		// directed table; typed pairs are the ones readable at a glance
		// ignored track straight after reset still closes an empty frame
		add_row(dir_row(63, 1234, 0, 0, 1, 1, 0, 0, 0));
		// unity gain, hard left and hard right pass the sample through
		add_row(dir_row(0, 8388607, 0, -100, 1, 1, 8388607, 0, 0));
		add_row(dir_row(7, -8388608, 0, 100, 1, 1, 0, -8388608, 0));
		// first track past the reset count is ignored
		add_row(dir_row(8, 5, 0, 0, 1, 1, 0, 0, 0));
		// full scale at +6 db centre clips both sides
		add_row(dir_row(1, 8388607, 60, 0, 1, 1, 8388607, 8388607, 1));
		// gain above range clamps to +6 db
		add_row(dir_row(2, -8388608, 1023, 0, 1, 1, -8388608, -8388608, 1));
		// pan beyond range clamps to the ends
		add_row(dir_row(3, 1000, 0, -128, 1, 1, 1000, 0, 0));
		add_row(dir_row(4, -1, 0, 127, 1, 1, 0, -1, 0));
		// two tracks summed into one frame
		add_row(dir_row(0, 5000, 0, -100, 0, 0, 0, 0, 0));
		add_row(dir_row(1, 3000, 0, 100, 1, 1, 5000, 3000, 0));
		// left side only saturates
		add_row(dir_row(0, 8388607, 0, -100, 0, 0, 0, 0, 0));
		add_row(dir_row(1, 8388607, 0, -100, 1, 1, 8388607, 0, 1));
		// last mark on an ignored track still emits the sums
		add_row(dir_row(0, 7777, 0, -100, 0, 0, 0, 0, 0));
		add_row(dir_row(63, -4321, 60, 0, 1, 1, 7777, 0, 0));
		// gain floor, gain below range, values either side of the ends
		add_row(dir_row(5, 8388607, -600, 0, 1, 0, 0, 0, 0));
		add_row(dir_row(6, -8388608, -1024, 37, 0, 0, 0, 0, 0));
		add_row(dir_row(2, 123456, 59, -1, 0, 0, 0, 0, 0));
		add_row(dir_row(3, -654321, -601, 1, 0, 0, 0, 0, 0));
		add_row(dir_row(4, 4194304, 61, 99, 1, 0, 0, 0, 0));
		add_row(dir_row(0, 0, 0, 0, 1, 1, 0, 0, 0));
		add_row(dir_row(1, 1, 0, 0, 1, 0, 0, 0, 0));
		add_row(dir_row(7, -2, 60, -99, 0, 0, 0, 0, 0));
		add_row(dir_row(0, 3, -300, -101, 1, 0, 0, 0, 0));

		// reset released at an edge so the block leaves reset on the following one
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_track(row.it, row.typed, row.want);
		end

		// full-scale hard-left and hard-right tracks back to back in one long frame,
		// with no idling on either side
		quiet = 1'b1;
		for (k = 0; k < FULL_SCALE_ITEMS; k++) begin
			row = (k % 2 == 0) ? dir_row(0, 8388607, 60, -100, 0, 0, 0, 0, 0)
				: dir_row(1, -8388608, 60, 100, k == FULL_SCALE_ITEMS - 1, 0, 0, 0, 0);
			send_track(row.it, 1'b0, '0);
		end
		quiet = 1'b0;

		// random phases, each at its own track count, written only once drained
		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_mix_drained();
			lim = (ph < 7) ? phase_limit[ph] : $urandom_range(64, 2);
			set_track_count(lim);
			quiet = (ph == 5);
			if (ph == 1) begin
				// receiver holds off while single-track frames keep coming, so the
				// block backs up and stalls its input
				rx_hold = 1'b1;
				for (k = 0; k < HOLD_ITEMS; k++) begin
					send_track(random_track($urandom_range(63), 1'b1), 1'b0, '0);
				end
			end
			start = n_counted;
			while (n_counted - start < PHASE_ITEMS) begin
				if ($urandom_range(99) < 75) begin
					// well-formed frame: tracks in order, last mark on the final one
					span = (trk_limit >= 2 && trk_limit <= 64) ? trk_limit : 8;
					if ($urandom_range(99) < 70 && span > 4) begin
						span = 4;
					end
					n = $urandom_range(span, 1);
					for (k = 0; k < n; k++) begin
						send_track(random_track(k, k == n - 1), 1'b0, '0);
					end
				end else begin
					send_track(random_track($urandom_range(63), $urandom_range(1)), 1'b0, '0);
				end
			end
			quiet = 1'b0;
		end

		wait_mix_drained();
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
